@@ sv/button_debounce_long_press_unit_defines.svh @@
// Assertion macros used by the button debouncer checker.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

// Concurrent assertion, masked while reset is high.
`define BDLP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define BDLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bdlp_pkg.sv @@
// Types, constants and helper functions of the button debouncer.
package bdlp_pkg;

   localparam int TIME_WIDTH      = 16;
   localparam int DELAY_WIDTH     = 16;
   localparam int CMP_WIDTH       = (TIME_WIDTH > DELAY_WIDTH) ? TIME_WIDTH : DELAY_WIDTH;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int REQ_TDATA_WIDTH = 8;
   localparam int RSP_TDATA_WIDTH = 8;

   localparam logic [TIME_WIDTH-1:0]  TIME_MAX               = '1;
   localparam logic [DELAY_WIDTH-1:0] DEBOUNCE_DELAY_RESET   = DELAY_WIDTH'(0);
   localparam logic [DELAY_WIDTH-1:0] LONG_PRESS_DELAY_RESET = DELAY_WIDTH'(1000);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE_DELAY    = 8'd0,
      CSR_LONG_PRESS_DELAY  = 8'd1,
      CSR_ACTIVE_LEVEL      = 8'd2,
      CSR_LONG_PRESS_ENABLE = 8'd3
   } csr_index_type;

   typedef enum logic {
      ACTION_TICK   = 1'b0,
      ACTION_CANCEL = 1'b1
   } action_type;

   typedef struct packed {
      logic [DELAY_WIDTH-1:0] debounce_delay;
      logic [DELAY_WIDTH-1:0] long_press_delay;
      logic                   active_level;
      logic                   long_press_enable;
   } cfg_type;

   typedef struct packed {
      action_type action;
      logic       pin_level;
   } req_item_type;

   // pressed_event sits in bit 0
   typedef struct packed {
      logic is_pressed;
      logic long_press_event;
      logic released_event;
      logic pressed_event;
   } rsp_item_type;

   // a saturated counter counts as having reached any delay
   function automatic logic reached(input logic [TIME_WIDTH-1:0]  elapsed,
                                    input logic [DELAY_WIDTH-1:0] delay);
      reached = (CMP_WIDTH'(elapsed) >= CMP_WIDTH'(delay)) || (elapsed == TIME_MAX);
   endfunction

endpackage

@@ sv/bdlp_csr.sv @@
// Configuration register file of the button debouncer.
module bdlp_csr import bdlp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_DELAY:    cfg_in.debounce_delay    = csr_data[DELAY_WIDTH-1:0];
            CSR_LONG_PRESS_DELAY:  cfg_in.long_press_delay  = csr_data[DELAY_WIDTH-1:0];
            CSR_ACTIVE_LEVEL:      cfg_in.active_level      = csr_data[0];
            CSR_LONG_PRESS_ENABLE: cfg_in.long_press_enable = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_delay    <= DEBOUNCE_DELAY_RESET;
         cfg_ff.long_press_delay  <= LONG_PRESS_DELAY_RESET;
         cfg_ff.active_level      <= 1'b0;
         cfg_ff.long_press_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/bdlp_core.sv @@
// Debounce state and per-item event logic.
module bdlp_core import bdlp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic                  level_ff, level_in;
   logic                  lockout_ff, lockout_in;
   logic                  long_done_ff, long_done_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;

   logic [TIME_WIDTH-1:0] count_adv;
   logic                  lock_hold;
   logic                  take;
   logic                  done_mid;
   logic                  long_hit;

   always_comb begin
      count_adv = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + TIME_WIDTH'(1);
      lock_hold = lockout_ff && !reached(count_adv, cfg.debounce_delay);
      take      = !lock_hold && (item.pin_level != level_ff);

      level_in   = take ? item.pin_level : level_ff;
      elapsed_in = take ? '0 : count_adv;
      lockout_in = lock_hold || take;
      done_mid   = (take && (item.pin_level == cfg.active_level)) ? 1'b0 : long_done_ff;

      long_hit = cfg.long_press_enable && (level_in == cfg.active_level) && !done_mid &&
                 reached(elapsed_in, cfg.long_press_delay);
      long_done_in = done_mid || long_hit;

      result.pressed_event    = take && (item.pin_level == cfg.active_level);
      result.released_event   = take && (item.pin_level != cfg.active_level);
      result.long_press_event = long_hit;
      result.is_pressed       = (level_in == cfg.active_level);

      // cancel: only the pending long press is dropped
      if (item.action == ACTION_CANCEL) begin
         level_in     = level_ff;
         elapsed_in   = elapsed_ff;
         lockout_in   = lockout_ff;
         long_done_in = 1'b1;
         result.pressed_event    = 1'b0;
         result.released_event   = 1'b0;
         result.long_press_event = 1'b0;
         result.is_pressed       = (level_ff == cfg.active_level);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= 1'b1;
         lockout_ff   <= 1'b0;
         long_done_ff <= 1'b1;
         elapsed_ff   <= TIME_MAX;
      end else if (step) begin
         level_ff     <= level_in;
         lockout_ff   <= lockout_in;
         long_done_ff <= long_done_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

@@ sv/button_debounce_long_press_unit.sv @@
// Top level of the button debouncer with long-press detection.
//
//   channel  | ports                  | payload
//   ---------+------------------------+------------------------------------------
//   request  | req_tvalid/req_tready  | tuser: action; tdata: pin_level
//   response | rsp_tvalid/rsp_tready  | tdata: pressed, released, long_press, is_pressed
//   config   | csr_valid/csr_ready    | csr_index, csr_data
//
// One item per clock cycle while rsp_tready stays high; a transferred request is held
// in the request register and passes the event logic into the result register.
// csr_ready is always high. Synchronous reset clears state and both valid flags.
// A stalled rsp_tready holds the result; one more item may wait in the request register.
module button_debounce_long_press_unit import bdlp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,  // [0] pin_level
   input  logic                       req_tuser,  // [0] action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,  // [0] pressed, [1] released,
                                                  // [2] long_press, [3] is_pressed
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type      cfg;
   rsp_item_type result;

   logic         req_valid_ff, req_valid_in;
   req_item_type req_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         advance;

   bdlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bdlp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // item moves to the result register when that one is free or being drained
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_item_ff.action    <= action_type'(req_tuser);
         req_item_ff.pin_level <= req_tdata[0];
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(rsp_item_ff);

endmodule

@@ sv/bdlp_checker.sv @@
// Port-level checker for the button debouncer, bound to the top level.
`include "button_debounce_long_press_unit_defines.svh"

module bdlp_checker import bdlp_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   `BDLP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `BDLP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")
   `BDLP_ASSERT(a_one_edge, clock, reset, rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]), "press and release together")
   `BDLP_ASSERT(a_press_level, clock, reset, rsp_tvalid && (rsp_tdata[0] || rsp_tdata[2]) |-> rsp_tdata[3], "press event without pressed level")
   `BDLP_ASSERT(a_release_level, clock, reset, rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[3], "release event with pressed level")

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the button debouncer with long-press detection.
`timescale 1ns / 1ps

module tb_top;
   import bdlp_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_UNUSED = 8'hFF;
   localparam int SCRIPT_LEN   = 34;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 150;
   localparam int HOLD_TICKS   = 120;
   localparam int SHOW_LIMIT   = 10;

   typedef struct packed {
      logic                       is_cfg;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [CSR_DATA_WIDTH-1:0]  data;
      action_type                 act;
      logic                       pin;
      logic                       known;
      rsp_item_type               want;
   } script_row;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // predictor state
   cfg_type                btn_cfg;
   logic                   btn_level;
   logic                   btn_lockout;
   logic                   btn_long_done;
   logic [TIME_WIDTH-1:0]  btn_ticks;

   rsp_item_type pending_events[$];
   rsp_item_type got_events, want_events;
   int           mismatches = 0;
   int           stall_left = 0;
   logic         idle_on = 1'b1;

   button_debounce_long_press_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [0] pin_level
      .req_tuser  (req_tuser),   // [0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] pressed, [1] released, [2] long_press, [3] is_pressed
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturated counter satisfies any delay
   function automatic logic delay_met(input logic [DELAY_WIDTH-1:0] delay);
      return ({16'b0, btn_ticks} >= {16'b0, delay}) || (btn_ticks == TIME_MAX);
   endfunction

   function automatic rsp_item_type next_events(input action_type act, input logic pin);
      rsp_item_type ev;
      ev = '0;
      if (act == ACTION_CANCEL) begin
         btn_long_done = 1'b1;
      end else begin
         if (btn_ticks != TIME_MAX)
            btn_ticks = btn_ticks + 1'b1;
         if (btn_lockout && delay_met(btn_cfg.debounce_delay))
            btn_lockout = 1'b0;
         if (!btn_lockout && pin != btn_level) begin
            btn_level   = pin;
            btn_ticks   = '0;
            btn_lockout = 1'b1;
            if (btn_level == btn_cfg.active_level) begin
               btn_long_done    = 1'b0;
               ev.pressed_event = 1'b1;
            end else begin
               ev.released_event = 1'b1;
            end
         end
         if (btn_cfg.long_press_enable && btn_level == btn_cfg.active_level &&
             !btn_long_done && delay_met(btn_cfg.long_press_delay)) begin
            btn_long_done       = 1'b1;
            ev.long_press_event = 1'b1;
         end
      end
      ev.is_pressed = (btn_level == btn_cfg.active_level);
      return ev;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_DEBOUNCE_DELAY:    btn_cfg.debounce_delay    = data[DELAY_WIDTH-1:0];
         CSR_LONG_PRESS_DELAY:  btn_cfg.long_press_delay  = data[DELAY_WIDTH-1:0];
         CSR_ACTIVE_LEVEL:      btn_cfg.active_level      = data[0];
         CSR_LONG_PRESS_ENABLE: btn_cfg.long_press_enable = data[0];
         default: ;
      endcase
   endfunction

   function automatic logic [DELAY_WIDTH-1:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return DELAY_WIDTH'($urandom_range(0, 4));
      else if (r < 80)
         return DELAY_WIDTH'($urandom_range(5, 24));
      else if (r < 86)
         return '1;
      else if (r < 92)
         return '0;
      else
         return DELAY_WIDTH'($urandom());
   endfunction

   // one transfer on the request channel; csr_valid drops here after a register batch
   task automatic send_item(input action_type act, input logic pin);
      int gap;
      csr_valid <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_WIDTH-1){1'b0}}, pin};
      do @(posedge clock); while (!req_tready);
      pending_events.push_back(next_events(act, pin));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
   endtask

   // receiver side: bursts of backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_events = rsp_item_type'(rsp_tdata[3:0]);
         if (pending_events.size() == 0) begin
            if (mismatches < SHOW_LIMIT)
               $display("%0t: unexpected result %b", $time, got_events);
            mismatches++;
         end else begin
            want_events = pending_events.pop_front();
            if (got_events.pressed_event    !== want_events.pressed_event ||
                got_events.released_event   !== want_events.released_event ||
                got_events.long_press_event !== want_events.long_press_event ||
                got_events.is_pressed       !== want_events.is_pressed) begin
               if (mismatches < SHOW_LIMIT)
                  $display("%0t: mismatch pressed/released/long/is_pressed exp %b%b%b%b got %b%b%b%b",
                           $time, want_events.pressed_event, want_events.released_event,
                           want_events.long_press_event, want_events.is_pressed,
                           got_events.pressed_event, got_events.released_event,
                           got_events.long_press_event, got_events.is_pressed);
               mismatches++;
            end
         end
      end
   end

   script_row script [0:SCRIPT_LEN-1] = '{
      // after reset: debounce 0, long press off, active low, level idle high
      '{1'b0, '0, '0, ACTION_TICK,   1'b1, 1'b1, 4'b0000},
      '{1'b0, '0, '0, ACTION_CANCEL, 1'b0, 1'b1, 4'b0000},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b1, 4'b1001},
      '{1'b0, '0, '0, ACTION_TICK,   1'b1, 1'b1, 4'b0010},
      // upper data bits are ignored
      '{1'b1, CSR_LONG_PRESS_ENABLE, 32'hFFFF_FFF1, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b1, CSR_LONG_PRESS_DELAY,  32'h0001_0000, ACTION_TICK, 1'b0, 1'b0, '0},
      // zero long-press delay: long press rides along with the press
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b1, 4'b1101},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b1, 4'b1000},
      '{1'b1, CSR_INDEX_UNUSED,      32'hFFFF_FFFF, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b1, CSR_DEBOUNCE_DELAY,    32'h00FF_0002, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b1, CSR_LONG_PRESS_DELAY,  32'h0000_0003, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b1, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      // cancel while a long press is pending
      '{1'b0, '0, '0, ACTION_CANCEL, 1'b1, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b1, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      // flip active level while held: is_pressed follows with no event
      '{1'b1, CSR_ACTIVE_LEVEL,      32'h0000_0001, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b1, 1'b0, '0},
      '{1'b1, CSR_DEBOUNCE_DELAY,    32'h0000_FFFF, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b1, CSR_LONG_PRESS_DELAY,  32'hFFFF_FFFF, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b1, 1'b0, '0},
      '{1'b1, CSR_DEBOUNCE_DELAY,    32'h0000_0000, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b1, CSR_LONG_PRESS_ENABLE, 32'h0000_0000, ACTION_TICK, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, ACTION_TICK,   1'b0, 1'b0, '0}
   };

   initial begin
      int                        n;
      int                        run_len;
      int                        roll;
      logic                      level;
      logic                      noisy;
      logic [CSR_DATA_WIDTH-1:0] data;

      btn_cfg       = '{DEBOUNCE_DELAY_RESET, LONG_PRESS_DELAY_RESET, 1'b0, 1'b0};
      btn_level     = 1'b1;
      btn_lockout   = 1'b0;
      btn_long_done = 1'b1;
      btn_ticks     = TIME_MAX;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            write_reg(script[i].idx, script[i].data);
         end else begin
            send_item(script[i].act, script[i].pin);
            if (script[i].known)
               pending_events[pending_events.size()-1] = script[i].want;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         idle_on <= (p % 3 != 2);
         data = $urandom();
         data[DELAY_WIDTH-1:0] = pick_delay();
         write_reg(CSR_DEBOUNCE_DELAY, data);
         data = $urandom();
         data[DELAY_WIDTH-1:0] = pick_delay();
         write_reg(CSR_LONG_PRESS_DELAY, data);
         data = $urandom();
         write_reg(CSR_ACTIVE_LEVEL, data);
         data = $urandom();
         data[0] = ($urandom_range(0, 3) != 0);
         write_reg(CSR_LONG_PRESS_ENABLE, data);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_INDEX_UNUSED, $urandom());

         n = 0;
         while (n < PHASE_ITEMS) begin
            // held level with some bounce; now and then a fully random stretch
            level   = $urandom_range(0, 1);
            noisy   = ($urandom_range(0, 9) == 0);
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(5, 30);
            for (int k = 0; k < run_len && n < PHASE_ITEMS; k++) begin
               roll = $urandom_range(0, 99);
               if (roll < 5)
                  send_item(ACTION_CANCEL, 1'($urandom_range(0, 1)));
               else if (noisy)
                  send_item(ACTION_TICK, 1'($urandom_range(0, 1)));
               else if (roll < 15)
                  send_item(ACTION_TICK, !level);
               else
                  send_item(ACTION_TICK, level);
               n++;
            end
         end
      end

      // long hold at the widest delays: lockout and long press stay pending
      idle_on <= 1'b0;
      write_reg(CSR_DEBOUNCE_DELAY, '0);
      write_reg(CSR_LONG_PRESS_DELAY, 32'h0000_FFFF);
      write_reg(CSR_ACTIVE_LEVEL, '0);
      write_reg(CSR_LONG_PRESS_ENABLE, 32'h0000_0001);
      send_item(ACTION_TICK, 1'b1);
      send_item(ACTION_TICK, 1'b1);
      write_reg(CSR_DEBOUNCE_DELAY, 32'h0000_FFFF);
      send_item(ACTION_TICK, 1'b0);
      for (int k = 0; k < HOLD_TICKS; k++)
         send_item(ACTION_TICK, (k < 100 && $urandom_range(0, 49) == 0));
      repeat (3) send_item(ACTION_TICK, 1'b1);

      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("** button_debounce_long_press_unit: PASSED **");
      else
         $display("** button_debounce_long_press_unit: FAILED **");
      $finish;
   end

   initial begin
      #(64'd10_000_000);
      $display("** button_debounce_long_press_unit: FAILED **");
      $finish;
   end

endmodule

@@ button_debounce_long_press_unit.f @@
+incdir+sv
sv/bdlp_pkg.sv
sv/bdlp_csr.sv
sv/bdlp_core.sv
sv/button_debounce_long_press_unit.sv
sv/bdlp_checker.sv
sim/tb_top.sv
